// ===== sv/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg
// Types and constants shared by the LRU key-value cache cells and top level.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  // Store geometry
  localparam int Capacity = 8;
  localparam int KeyBits  = 32;
  localparam int DataBits = 32;

  // Request type codes
  localparam logic ReqGet = 1'b0;
  localparam logic ReqPut = 1'b1;

  // Request and response payloads
  typedef struct packed {
    logic        req_type;
    logic [31:0] key;
    logic [31:0] wdata;
  } lkvc_req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] rdata;
  } lkvc_rsp_t;

  // Token that walks down the row of cells, one cell per cycle.
  //   upd   : 0 = search pass, 1 = update pass
  //   done  : update pass has already placed its carried entry
  //   key   : request key
  //   data  : data found by the search pass
  //   ckey/cdata : entry carried toward the next cell in the update pass
  typedef struct packed {
    logic                live;
    logic                upd;
    logic                done;
    logic                hit;
    logic [KeyBits-1:0]  key;
    logic [DataBits-1:0] data;
    logic [KeyBits-1:0]  ckey;
    logic [DataBits-1:0] cdata;
  } lkvc_tok_t;

  // Controller states
  typedef enum logic [1:0] {
    StIdle,
    StBusy,
    StDone
  } lkvc_state_e;

endpackage

// ===== sv/lkvc_cell.sv =====
// ----------------------------------------------------------------------------
// lkvc_cell
// One entry of the recency-ordered store. Cell position equals recency rank:
// the update pass shifts entries one cell toward the tail until it reaches
// the old copy of the key or a free cell; whatever leaves the last cell is
// evicted.
// ----------------------------------------------------------------------------
module lkvc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lkvc_pkg::lkvc_tok_t tok_i,
  output lkvc_pkg::lkvc_tok_t tok_o
);

  logic                          vld_q, vld_d;
  logic [lkvc_pkg::KeyBits-1:0]  key_q, key_d;
  logic [lkvc_pkg::DataBits-1:0] val_q, val_d;
  lkvc_pkg::lkvc_tok_t           tok_q, tok_d;
  logic                          match;

  assign match = vld_q && (key_q == tok_i.key);

  // Compare, swap carried entry, and advance token
  always_comb begin
    tok_d = tok_i;
    vld_d = vld_q;
    key_d = key_q;
    val_d = val_q;
    if (tok_i.live) begin
      if (!tok_i.upd) begin
        if (match) begin
          tok_d.hit  = 1'b1;
          tok_d.data = val_q;
        end
      end else if (!tok_i.done) begin
        vld_d = 1'b1;
        key_d = tok_i.ckey;
        val_d = tok_i.cdata;
        if (match) begin
          tok_d.done = 1'b1;
          tok_d.hit  = 1'b1;
        end else if (!vld_q) begin
          tok_d.done = 1'b1;
        end else begin
          tok_d.ckey  = key_q;
          tok_d.cdata = val_q;
        end
      end
    end
  end

  // Hold valid bit and token under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      tok_q <= '0;
    end else begin
      vld_q <= vld_d;
      tok_q <= tok_d;
    end
  end

  // Entry payload
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

  assign tok_o = tok_q;

endmodule

// ===== sv/lru_key_value_cache_top.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key-value cache with LRU replacement, built as a row of
// cells ordered by recency with a token that walks the row.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------
//   req     | in        | req_valid_i/req_stall_o | req_i (type,key,data)
//   rsp     | out       | rsp_valid_o/rsp_stall_i | rsp_o (hit,rdata)
//
// A put takes one update walk over the Capacity cells. A get takes a search
// walk; a get hit adds an update walk that moves the entry to the front.
// Reset empties the store at once. The response register lets the next
// request enter while a response is stalled; a finished result waits in the
// controller if the response register is still full.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_stall_o,
  input  lkvc_pkg::lkvc_req_t req_i,
  output logic                rsp_valid_o,
  input  logic                rsp_stall_i,
  output lkvc_pkg::lkvc_rsp_t rsp_o
);

  lkvc_pkg::lkvc_state_e         state_q, state_d;
  lkvc_pkg::lkvc_tok_t           tok_q, tok_d;
  lkvc_pkg::lkvc_tok_t           chain [lkvc_pkg::Capacity+1];
  lkvc_pkg::lkvc_tok_t           tail;
  logic                          is_put_q, is_put_d;
  logic                          res_hit_q, res_hit_d;
  logic [lkvc_pkg::DataBits-1:0] res_data_q, res_data_d;
  logic                          rsp_valid_q, rsp_valid_d;
  lkvc_pkg::lkvc_rsp_t           rsp_q, rsp_d;
  logic                          out_free;

  // Row of cells
  assign chain[0] = tok_q;
  for (genvar g = 0; g < lkvc_pkg::Capacity; g++) begin : g_cell
    lkvc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1])
    );
  end
  assign tail = chain[lkvc_pkg::Capacity];

  assign out_free    = !rsp_valid_q || !rsp_stall_i;
  assign req_stall_o = (state_q != lkvc_pkg::StIdle);

  // Next state, token injection and result capture
  always_comb begin
    state_d     = state_q;
    tok_d       = '0;
    is_put_d    = is_put_q;
    res_hit_d   = res_hit_q;
    res_data_d  = res_data_q;
    rsp_valid_d = rsp_valid_q && rsp_stall_i;
    rsp_d       = rsp_q;
    case (state_q)
      lkvc_pkg::StIdle: begin
        if (req_valid_i) begin
          is_put_d   = (req_i.req_type == lkvc_pkg::ReqPut);
          tok_d.live = 1'b1;
          tok_d.upd  = (req_i.req_type == lkvc_pkg::ReqPut);
          tok_d.key  = lkvc_pkg::KeyBits'(req_i.key);
          tok_d.ckey = lkvc_pkg::KeyBits'(req_i.key);
          tok_d.cdata = (req_i.req_type == lkvc_pkg::ReqPut) ?
                        lkvc_pkg::DataBits'(req_i.wdata) : '0;
          state_d    = lkvc_pkg::StBusy;
        end
      end
      lkvc_pkg::StBusy: begin
        if (tail.live) begin
          if (!tail.upd && tail.hit) begin
            // Get hit: walk again to move the entry to the front
            res_data_d  = tail.data;
            tok_d.live  = 1'b1;
            tok_d.upd   = 1'b1;
            tok_d.key   = tail.key;
            tok_d.ckey  = tail.key;
            tok_d.cdata = tail.data;
          end else begin
            res_hit_d = tail.upd && tail.hit;
            if (is_put_q || !tail.upd) begin
              res_data_d = '0;
            end
            state_d = lkvc_pkg::StDone;
          end
        end
      end
      lkvc_pkg::StDone: begin
        if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_d.hit   = res_hit_q;
          rsp_d.rdata = 32'(res_data_q);
          state_d     = lkvc_pkg::StIdle;
        end
      end
      default: begin
        state_d = lkvc_pkg::StIdle;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lkvc_pkg::StIdle;
      tok_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tok_q       <= tok_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    is_put_q   <= is_put_d;
    res_hit_q  <= res_hit_d;
    res_data_q <= res_data_d;
    rsp_q      <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== dv/tb_lru_key_value_cache_top.sv =====
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_top
// Self-checking bench for the LRU key-value cache. Requests are predicted as
// they are accepted by an in-bench LRU model, and every response is checked
// in order against that prediction. A short directed run covers the empty
// store, the extreme keys and data, update, fill and eviction. Random traffic
// then works a small key pool so hits, misses and evictions stay frequent.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PoolSize    = 12;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 2 * lkvc_pkg::Capacity + 12;
  localparam int PhaseItems  = 345;

  // Reference LRU store plus the queue of responses still owed by the block
  class lru_scoreboard;
    localparam int RankBits = $clog2(lkvc_pkg::Capacity);

    bit                          ent_valid [lkvc_pkg::Capacity];
    bit [lkvc_pkg::KeyBits-1:0]  ent_key   [lkvc_pkg::Capacity];
    bit [lkvc_pkg::DataBits-1:0] ent_data  [lkvc_pkg::Capacity];
    bit [RankBits-1:0]           ent_rank  [lkvc_pkg::Capacity];
    lkvc_pkg::lkvc_rsp_t         owed_q[$];
    int                          errors;

    function new();
      foreach (ent_valid[i]) ent_valid[i] = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Age every valid entry that is more recent than limit
    function void age_entries(int limit);
      foreach (ent_valid[i]) begin
        if (ent_valid[i] && int'(ent_rank[i]) < limit) ent_rank[i]++;
      end
    endfunction

    // Apply one accepted request and queue the response it must produce
    function void note_request(lkvc_pkg::lkvc_req_t r);
      lkvc_pkg::lkvc_rsp_t        rsp;
      bit [lkvc_pkg::KeyBits-1:0] k;
      int                         slot;
      int                         free_slot;
      int                         oldest;
      int                         oldest_rank;
      int                         target;
      k           = r.key[lkvc_pkg::KeyBits-1:0];
      slot        = -1;
      free_slot   = -1;
      oldest      = -1;
      oldest_rank = 0;
      rsp         = '0;
      for (int i = 0; i < lkvc_pkg::Capacity; i++) begin
        if (ent_valid[i]) begin
          if (ent_key[i] == k && slot < 0) slot = i;
          if (oldest < 0 || int'(ent_rank[i]) >= oldest_rank) begin
            oldest      = i;
            oldest_rank = int'(ent_rank[i]);
          end
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (slot >= 0) begin
        // Hit: promote to most recent, then write or read
        age_entries(int'(ent_rank[slot]));
        ent_rank[slot] = '0;
        if (r.req_type == lkvc_pkg::ReqPut) ent_data[slot] = r.wdata[lkvc_pkg::DataBits-1:0];
        else rsp.rdata = ent_data[slot];
        rsp.hit = 1'b1;
      end else if (r.req_type == lkvc_pkg::ReqPut) begin
        // Miss on put: take the lowest free entry, else evict the oldest
        if (free_slot >= 0) begin
          target = free_slot;
          age_entries(lkvc_pkg::Capacity);
        end else begin
          target = oldest;
          age_entries(oldest_rank);
        end
        ent_valid[target] = 1'b1;
        ent_key[target]   = k;
        ent_data[target]  = r.wdata[lkvc_pkg::DataBits-1:0];
        ent_rank[target]  = '0;
      end
      owed_q.insert(owed_q.size(), rsp);
    endfunction

    task report(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    // Compare one accepted response against the oldest owed one
    task check_response(lkvc_pkg::lkvc_rsp_t got);
      lkvc_pkg::lkvc_rsp_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("response hit=%0b rdata=%08h with no request owed",
                         got.hit, got.rdata));
        return;
      end
      want = owed_q.pop_front();
      if (got.hit !== want.hit)
        report($sformatf("hit %0b, expected %0b", got.hit, want.hit));
      if (got.rdata !== want.rdata)
        report($sformatf("rdata %08h, expected %08h", got.rdata, want.rdata));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                req_valid_i;
  logic                req_stall_o;
  lkvc_pkg::lkvc_req_t req_i;
  logic                rsp_valid_o;
  logic                rsp_stall_i;
  lkvc_pkg::lkvc_rsp_t rsp_o;

  lru_scoreboard              sb;
  int                         tx_idle_pct;
  int                         rx_idle_pct;
  int                         hold_ask;
  bit [lkvc_pkg::KeyBits-1:0] key_pool [PoolSize];

  lru_key_value_cache_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Hard limit on the run
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Check every accepted response
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && !rsp_stall_i) sb.check_response(rsp_o);
  end

  // Drive response stall: random, or a long hold-off when asked
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen   = 0;
    hold_left   = 0;
    rsp_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall_i <= 1'b1;
      end else begin
        rsp_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  function automatic lkvc_pkg::lkvc_req_t make_req(logic op, logic [31:0] k,
                                                   logic [31:0] d);
    lkvc_pkg::lkvc_req_t r;
    r.req_type = op;
    r.key      = k;
    r.wdata    = d;
    return r;
  endfunction

  // Random request, mostly on the key pool so the store keeps turning over
  function automatic lkvc_pkg::lkvc_req_t rand_req();
    lkvc_pkg::lkvc_req_t r;
    r.req_type = ($urandom_range(0, 99) < 45) ? lkvc_pkg::ReqGet : lkvc_pkg::ReqPut;
    if ($urandom_range(0, 99) < 85) r.key = key_pool[$urandom_range(0, PoolSize - 1)];
    else r.key = $urandom();
    r.wdata = $urandom();
    return r;
  endfunction

  // Offer one request at the falling edge and hold it until accepted
  task automatic send_req(lkvc_pkg::lkvc_req_t r);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_valid_i <= 1'b0;
      req_i       <= {1'($urandom()), $urandom(), $urandom()};
      @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
    sb.note_request(r);
    @(negedge clk_i);
  endtask

  // Park the request side until every owed response is back
  task automatic wait_drained();
    req_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic run_random(int n, int hold_at, int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_ask++;
      if (i == pause_at) wait_drained();
      if ($urandom_range(0, 99) < 8) key_pool[$urandom_range(0, PoolSize - 1)] = $urandom();
      send_req(rand_req());
    end
  endtask

  // Main sequence
  initial begin
    sb          = new();
    tx_idle_pct = 15;
    rx_idle_pct = 79;
    hold_ask    = 0;
    rst_ni      = 1'b0;
    req_valid_i = 1'b0;
    req_i       = '0;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty store, extremes, update, fill and eviction
    send_req(make_req(lkvc_pkg::ReqGet, 32'h0000_0000, 32'h0000_0000));
    send_req(make_req(lkvc_pkg::ReqPut, 32'h0000_0000, 32'hFFFF_FFFF));
    send_req(make_req(lkvc_pkg::ReqPut, 32'hFFFF_FFFF, 32'h0000_0000));
    send_req(make_req(lkvc_pkg::ReqGet, 32'h0000_0000, 32'h0000_0000));
    send_req(make_req(lkvc_pkg::ReqGet, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_req(make_req(lkvc_pkg::ReqPut, 32'h0000_0000, 32'h5A5A_A5A5));
    send_req(make_req(lkvc_pkg::ReqGet, 32'h0000_0000, 32'h1234_5678));
    send_req(make_req(lkvc_pkg::ReqGet, 32'h1234_5678, 32'h0000_0000));
    for (int i = 1; i <= lkvc_pkg::Capacity - 2; i++)
      send_req(make_req(lkvc_pkg::ReqPut, 32'h1000_0000 + i, 32'hC0DE_0000 + i));
    send_req(make_req(lkvc_pkg::ReqGet, 32'hFFFF_FFFF, 32'h0000_0000));
    send_req(make_req(lkvc_pkg::ReqPut, 32'hAAAA_5555, 32'h5555_AAAA));
    send_req(make_req(lkvc_pkg::ReqGet, 32'h0000_0000, 32'h0000_0000));
    send_req(make_req(lkvc_pkg::ReqPut, 32'h5555_AAAA, 32'hAAAA_5555));
    send_req(make_req(lkvc_pkg::ReqGet, 32'h1000_0001, 32'h0000_0000));
    send_req(make_req(lkvc_pkg::ReqGet, 32'h1000_0003, 32'h0000_0000));
    send_req(make_req(lkvc_pkg::ReqPut, 32'h1000_0003, 32'h8000_0001));
    send_req(make_req(lkvc_pkg::ReqGet, 32'h1000_0003, 32'h0000_0000));

    // Random: fast sender with busy receiver, then swapped, then full rate
    run_random(PhaseItems, -1, -1);
    tx_idle_pct = 79;
    rx_idle_pct = 15;
    run_random(PhaseItems, -1, 150);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(PhaseItems, 100, 220);

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d responses never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
